/* hw/rtl/tnr_pkg.sv */
`default_nettype none

package tnr_pkg;

  // list geometry
  localparam int LIST_DEPTH    = 10;
  localparam int NUM_LISTS     = 3;
  localparam int NUM_SIZE_REGS = 3;
  localparam int TOTAL_ENTRIES = NUM_LISTS * LIST_DEPTH;

  localparam int ADDR_W = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

  // field widths
  localparam int SEL_W      = 2;
  localparam int ID_W       = 32;
  localparam int SCORE_W    = 32;
  localparam int RANK_W     = 4;
  localparam int SIZE_W     = 4;
  localparam int IN_DATA_W  = ID_W + SCORE_W;
  localparam int OUT_DATA_W = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIST0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIST1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIST2 = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd10;

  typedef struct packed {
    logic        [ID_W-1:0]    id;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic id_match;
    logic score_le;
  } cmp_res_t;

endpackage

`default_nettype wire

/* hw/rtl/tnr_ram.sv */
`default_nettype none

module tnr_ram #(
  parameter int DEPTH  = 30,
  parameter int ADDR_W = 5,
  parameter int WIDTH  = 64
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tnr_cmp.sv */
`default_nettype none

// shared compare unit: id equality and score ordering of one stored entry
module tnr_cmp (
  input  wire tnr_pkg::entry_t   entry,
  input  wire logic [tnr_pkg::ID_W-1:0]           key_id,
  input  wire logic signed [tnr_pkg::SCORE_W-1:0] key_score,
  output tnr_pkg::cmp_res_t      res
);

  always_comb begin
    res.id_match = (entry.id == key_id);
    res.score_le = (entry.score <= key_score);
  end

endmodule

`default_nettype wire

/* hw/rtl/top_n_ranking_list_update.sv */
`default_nettype none

// channel  | dir | transfer when      | contents
// ---------+-----+--------------------+-------------------------------------------
// s_*      | in  | s_tvalid&&s_tready | tuser: list_select; tdata: member_id, new_score
// m_*      | out | m_tvalid&&m_tready | tdata: changed, final_rank
// cfg_*    | in  | cfg_we             | cfg_index selects size_list0..2, cfg_data
//
// an update scans the n slots of the selected list one per cycle through the
// single ram read port and the shared compare unit, then each of the m shifted
// entries is read through the read port and written back through the write port;
// an absent member scoring too low answers straight after the scan; no list
// selected or a size of zero answers straight from idle, with no scan
// reset clears the size registers to ten and the per-entry valid bits; an entry
// never written reads as zero
// s_tready is high only while idle; a finished result sits in the output register
// and the next update may be taken while it waits for m_tready

module top_n_ranking_list_update (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [tnr_pkg::IN_DATA_W-1:0]       s_tdata,   // member_id, new_score
  input  wire logic [tnr_pkg::SEL_W-1:0]           s_tuser,   // list_select
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [tnr_pkg::OUT_DATA_W-1:0]      m_tdata,   // changed, final_rank, zero pad
  input  wire logic                                cfg_we,
  input  wire logic [tnr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tnr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ADDR_W  = tnr_pkg::ADDR_W;
  localparam int CNT_W   = tnr_pkg::CNT_W;
  localparam int BASE_W  = ADDR_W + 8;
  localparam int RWIDE_W = (CNT_W > tnr_pkg::RANK_W) ? CNT_W : tnr_pkg::RANK_W;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SCAN    = 7'b0000010,
    ST_DECIDE  = 7'b0000100,
    ST_MOVE_RD = 7'b0001000,
    ST_MOVE_WR = 7'b0010000,
    ST_PUT     = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  state_t state;

  logic [tnr_pkg::SIZE_W-1:0] size_reg [tnr_pkg::NUM_SIZE_REGS];

  // item registers
  logic [tnr_pkg::ID_W-1:0]           id_q;
  logic signed [tnr_pkg::SCORE_W-1:0] score_q;
  logic [ADDR_W-1:0]                  base_addr;
  logic [CNT_W-1:0]                   n_q;

  // scan bookkeeping
  logic [CNT_W-1:0] scan_cnt;
  logic             rd_pend;
  logic [CNT_W-1:0] rd_idx_q;
  logic             p_found;
  logic             f_found;
  logic [CNT_W-1:0] ppos;
  logic [CNT_W-1:0] fpos;

  // shift bookkeeping
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] tgt;
  logic             dir_down;

  logic             res_changed;
  logic [CNT_W-1:0] res_rank;

  // valid bits for the entry store
  logic valid [tnr_pkg::TOTAL_ENTRIES];
  logic valid_q;

  // ram port
  logic                         ram_re;
  logic [ADDR_W-1:0]            ram_raddr;
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [tnr_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [tnr_pkg::ENTRY_W-1:0]  ram_rdata;

  tnr_pkg::entry_t   entry_rd;
  tnr_pkg::entry_t   entry_new;
  tnr_pkg::cmp_res_t cmp_res;

  // decoded input
  logic [tnr_pkg::SEL_W-1:0] in_sel;
  logic                      in_sel_ok;
  logic [7:0]                in_size;
  logic [7:0]                in_n_full;
  logic [CNT_W-1:0]          in_n;
  logic [BASE_W-1:0]         in_base;

  logic             move_go;
  logic [CNT_W-1:0] src_idx;
  logic [RWIDE_W-1:0] rank_wide;
  logic             s_xfer;

  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;

  always_comb begin
    in_sel    = s_tuser;
    in_sel_ok = (32'(in_sel) < tnr_pkg::NUM_LISTS) && (32'(in_sel) < tnr_pkg::NUM_SIZE_REGS);
    in_size   = '0;
    for (int k = 0; k < tnr_pkg::NUM_SIZE_REGS; k++) begin
      if (32'(in_sel) == k) begin
        in_size = 8'(size_reg[k]);
      end
    end
    // a size above the depth counts as the depth
    in_n_full = (in_size > 8'(tnr_pkg::LIST_DEPTH)) ? 8'(tnr_pkg::LIST_DEPTH) : in_size;
    in_n      = in_n_full[CNT_W-1:0];
    in_base   = BASE_W'(in_sel) * BASE_W'(tnr_pkg::LIST_DEPTH);
  end

  // shift direction: down copies toward higher slots, up toward lower
  assign move_go = dir_down ? (cur > tgt) : (cur < tgt);
  assign src_idx = dir_down ? (cur - CNT_W'(1)) : (cur + CNT_W'(1));

  assign entry_rd        = valid_q ? tnr_pkg::entry_t'(ram_rdata) : '0;
  assign entry_new.id    = id_q;
  assign entry_new.score = score_q;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = base_addr + ADDR_W'(scan_cnt);
    ram_we    = 1'b0;
    ram_waddr = base_addr + ADDR_W'(cur);
    ram_wdata = entry_rd;
    case (state)
      ST_SCAN: begin
        ram_re = (scan_cnt < n_q);
      end
      ST_MOVE_RD: begin
        ram_re    = move_go;
        ram_raddr = base_addr + ADDR_W'(src_idx);
      end
      ST_MOVE_WR: begin
        ram_we = 1'b1;
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = base_addr + ADDR_W'(tgt);
        ram_wdata = entry_new;
      end
      default: begin
      end
    endcase
  end

  tnr_ram #(
    .DEPTH  (tnr_pkg::TOTAL_ENTRIES),
    .ADDR_W (ADDR_W),
    .WIDTH  (tnr_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tnr_cmp u_cmp (
    .entry     (entry_rd),
    .key_id    (id_q),
    .key_score (score_q),
    .res       (cmp_res)
  );

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < tnr_pkg::NUM_SIZE_REGS; k++) begin
        size_reg[k] <= tnr_pkg::SIZE_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        tnr_pkg::CFG_SIZE_LIST0: size_reg[0] <= cfg_data;
        tnr_pkg::CFG_SIZE_LIST1: size_reg[1] <= cfg_data;
        tnr_pkg::CFG_SIZE_LIST2: size_reg[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // valid bits, read alongside the ram
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < tnr_pkg::TOTAL_ENTRIES; k++) begin
        valid[k] <= 1'b0;
      end
      valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        valid_q <= valid[ram_raddr];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == ST_SCAN) && ram_re;
      case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            // scan start values
            scan_cnt <= '0;
            p_found  <= 1'b0;
            f_found  <= 1'b0;
            ppos     <= in_n;
            fpos     <= in_n;
            if (!in_sel_ok || (in_n == '0)) begin
              // no list or an empty list: nothing moves, rank zero
              res_changed <= 1'b0;
              res_rank    <= '0;
              state       <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (ram_re) begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
          if (rd_pend) begin
            if (cmp_res.id_match && !p_found) begin
              p_found <= 1'b1;
              ppos    <= rd_idx_q;
            end
            if (cmp_res.score_le && !f_found) begin
              f_found <= 1'b1;
              fpos    <= rd_idx_q;
            end
          end
          if ((scan_cnt == n_q) && !rd_pend) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if ((ppos == n_q) && (fpos == n_q)) begin
            // absent and too low
            res_changed <= 1'b0;
            res_rank    <= n_q;
            state       <= ST_DONE;
          end else if (ppos == n_q) begin
            // new member, last entry falls off
            dir_down <= 1'b1;
            cur      <= n_q - CNT_W'(1);
            tgt      <= fpos;
            state    <= ST_MOVE_RD;
          end else if (fpos <= ppos) begin
            // moves up or stays put
            dir_down <= 1'b1;
            cur      <= ppos;
            tgt      <= fpos;
            state    <= ST_MOVE_RD;
          end else begin
            // moves down, lands one before the first slot not above it
            dir_down <= 1'b0;
            cur      <= ppos;
            tgt      <= fpos - CNT_W'(1);
            state    <= ST_MOVE_RD;
          end
        end
        ST_MOVE_RD: begin
          state <= move_go ? ST_MOVE_WR : ST_PUT;
        end
        ST_MOVE_WR: begin
          cur   <= src_idx;
          state <= ST_MOVE_RD;
        end
        ST_PUT: begin
          res_changed <= 1'b1;
          res_rank    <= tgt;
          state       <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      id_q      <= s_tdata[tnr_pkg::ID_W-1:0];
      score_q   <= s_tdata[tnr_pkg::IN_DATA_W-1:tnr_pkg::ID_W];
      base_addr <= in_base[ADDR_W-1:0];
      n_q       <= in_n;
    end
    if (ram_re) begin
      rd_idx_q <= scan_cnt;
    end
  end

  // output register
  assign rank_wide = RWIDE_W'(res_rank);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'b000, rank_wide[tnr_pkg::RANK_W-1:0], res_changed};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tnr_checker.sv */
`default_nettype none

module tnr_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [tnr_pkg::OUT_DATA_W-1:0]    m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one update at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an update is in progress");

  // a new result appears only at the end of an update
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without an update in progress");

  // padding bits of the result stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[tnr_pkg::OUT_DATA_W-1:tnr_pkg::RANK_W+1] == '0))
    else $error("result padding not zero");

endmodule

bind top_n_ranking_list_update tnr_checker u_tnr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
